// File: src/assert_macros.svh
// Assertion macros shared by the contour cell unit.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define MSC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("msc assertion failed");

// Condition that must never hold.
`define MSC_ASSERT_NEVER(name, cond) \
	`MSC_ASSERT(name, !(cond))

`endif

// File: src/msc_pkg.sv
// Types and constants of the marching-squares contour cell unit.
// No dependencies.
package msc_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int HEIGHT_BITS = 16;
	localparam int COORD_W     = 26;
	localparam int IDX_W       = 10;
	localparam int PITCH_W     = 16;

	localparam logic [1:0] CFG_LEVEL   = 2'd0;
	localparam logic [1:0] CFG_PITCH_X = 2'd1;
	localparam logic [1:0] CFG_PITCH_Y = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]       cell_col;
		logic [IDX_W-1:0]       cell_row;
		logic [HEIGHT_BITS-1:0] height_bl;
		logic [HEIGHT_BITS-1:0] height_br;
		logic [HEIGHT_BITS-1:0] height_tr;
		logic [HEIGHT_BITS-1:0] height_tl;
	} cell_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic               last_segment;
	} seg_t;

	typedef struct packed {
		logic [HEIGHT_BITS-1:0] level;
		logic [PITCH_W-1:0]     pitch_x;
		logic [PITCH_W-1:0]     pitch_y;
	} cfg_t;

	// classified cell with edge fractions, one queue entry
	typedef struct packed {
		logic [IDX_W-1:0]   cell_col;
		logic [IDX_W-1:0]   cell_row;
		logic [3:0]         code;
		logic               hi;
		logic [FRAC_BITS:0] t_b;
		logic [FRAC_BITS:0] t_r;
		logic [FRAC_BITS:0] t_t;
		logic [FRAC_BITS:0] t_l;
	} qent_t;

	typedef enum logic [1:0] {E_BOTTOM, E_RIGHT, E_TOP, E_LEFT} edge_t;

	typedef struct packed {
		logic  two;
		edge_t a0;
		edge_t b0;
		edge_t a1;
		edge_t b1;
	} plan_t;

	// segment plan per corner code, saddles for a low corner sum
	localparam plan_t PLAN_LO [16] = '{
		'{1'b0, E_LEFT,   E_BOTTOM, E_LEFT,   E_BOTTOM},
		'{1'b0, E_LEFT,   E_BOTTOM, E_LEFT,   E_BOTTOM},
		'{1'b0, E_BOTTOM, E_RIGHT,  E_BOTTOM, E_RIGHT},
		'{1'b0, E_LEFT,   E_RIGHT,  E_LEFT,   E_RIGHT},
		'{1'b0, E_RIGHT,  E_TOP,    E_RIGHT,  E_TOP},
		'{1'b1, E_LEFT,   E_BOTTOM, E_TOP,    E_RIGHT},
		'{1'b0, E_BOTTOM, E_TOP,    E_BOTTOM, E_TOP},
		'{1'b0, E_LEFT,   E_TOP,    E_LEFT,   E_TOP},
		'{1'b0, E_LEFT,   E_TOP,    E_LEFT,   E_TOP},
		'{1'b0, E_BOTTOM, E_TOP,    E_BOTTOM, E_TOP},
		'{1'b1, E_LEFT,   E_TOP,    E_BOTTOM, E_RIGHT},
		'{1'b0, E_RIGHT,  E_TOP,    E_RIGHT,  E_TOP},
		'{1'b0, E_LEFT,   E_RIGHT,  E_LEFT,   E_RIGHT},
		'{1'b0, E_BOTTOM, E_RIGHT,  E_BOTTOM, E_RIGHT},
		'{1'b0, E_LEFT,   E_BOTTOM, E_LEFT,   E_BOTTOM},
		'{1'b0, E_LEFT,   E_BOTTOM, E_LEFT,   E_BOTTOM}
	};

	// a high saddle uses the pairing of the complementary saddle
	function automatic plan_t msc_plan(logic [3:0] code, logic hi);
		plan_t p;
		p = PLAN_LO[code];
		if (hi && p.two) begin
			p = PLAN_LO[~code];
		end
		return p;
	endfunction

endpackage

// File: src/msc_front.sv
// Front part: classifies cells and runs four pipelined edge dividers.
// Depends on msc_pkg.
module msc_front #(
	parameter int GRID_CELLS = 1023
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cell_valid,
	output logic          cell_stall,
	input  msc_pkg::cell_t cell_data,
	input  msc_pkg::cfg_t  cfg,
	output logic          push,
	output msc_pkg::qent_t push_data,
	input  logic          full
);
	import msc_pkg::*;

	typedef enum logic [1:0] {K_DIV, K_ZERO, K_FLAT, K_FULL} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [HEIGHT_BITS-1:0] rem;
		logic [HEIGHT_BITS-1:0] den;
		logic [FRAC_BITS-1:0]   quo;
	} lane_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_col;
		logic [IDX_W-1:0] cell_row;
		logic [3:0]       code;
		logic             hi;
	} info_t;

	function automatic lane_t edge_setup(logic [HEIGHT_BITS-1:0] va,
		logic [HEIGHT_BITS-1:0] vb, logic [HEIGHT_BITS-1:0] lvl);
		lane_t          l;
		logic [HEIGHT_BITS:0] diff, num, an, ad;
		diff = {1'b0, vb} - {1'b0, va};
		num  = {1'b0, lvl} - {1'b0, va};
		an   = num[HEIGHT_BITS] ? (~num + 1'b1) : num;
		ad   = diff[HEIGHT_BITS] ? (~diff + 1'b1) : diff;
		l.rem = an[HEIGHT_BITS-1:0];
		l.den = ad[HEIGHT_BITS-1:0];
		l.quo = '0;
		if (diff == '0) begin
			l.kind = K_FLAT;
		end else if (num == '0 || num[HEIGHT_BITS] != diff[HEIGHT_BITS]) begin
			l.kind = K_ZERO;
		end else if (an >= ad) begin
			l.kind = K_FULL;
		end else begin
			l.kind = K_DIV;
		end
		return l;
	endfunction

	// one restoring division step
	function automatic lane_t div_step(lane_t l);
		lane_t          n;
		logic [HEIGHT_BITS:0] rem2, sub;
		logic           ge;
		rem2  = {l.rem, 1'b0};
		sub   = rem2 - {1'b0, l.den};
		ge    = rem2 >= {1'b0, l.den};
		n     = l;
		n.rem = ge ? sub[HEIGHT_BITS-1:0] : rem2[HEIGHT_BITS-1:0];
		n.quo = {l.quo[FRAC_BITS-2:0], ge};
		return n;
	endfunction

	function automatic logic [FRAC_BITS:0] t_value(lane_t l);
		logic [FRAC_BITS:0] t;
		case (l.kind)
			K_ZERO:  t = '0;
			K_FLAT:  t = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
			K_FULL:  t = (FRAC_BITS+1)'(1) << FRAC_BITS;
			default: t = {1'b0, l.quo};
		endcase
		return t;
	endfunction

	logic  vld_q  [0:FRAC_BITS];
	info_t info_q [0:FRAC_BITS];
	lane_t lane_q [0:FRAC_BITS][0:3];

	logic  en, in_grid, produces, hi;
	logic  [3:0] code;
	logic  [HEIGHT_BITS+1:0] sum;
	lane_t setup [0:3];

	assign en         = !(vld_q[FRAC_BITS] && full);
	assign cell_stall = !en;
	assign push       = vld_q[FRAC_BITS] && !full;

	always_comb begin
		in_grid  = (int'(cell_data.cell_col) < GRID_CELLS)
			&& (int'(cell_data.cell_row) < GRID_CELLS);
		code     = {cell_data.height_tl >= cfg.level, cell_data.height_tr >= cfg.level,
			cell_data.height_br >= cfg.level, cell_data.height_bl >= cfg.level};
		produces = in_grid && code != '0 && code != '1;
		sum      = (HEIGHT_BITS+2)'(cell_data.height_bl)
			+ (HEIGHT_BITS+2)'(cell_data.height_br)
			+ (HEIGHT_BITS+2)'(cell_data.height_tr)
			+ (HEIGHT_BITS+2)'(cell_data.height_tl);
		hi       = sum >= {cfg.level, 2'b00};
		setup[0] = edge_setup(cell_data.height_bl, cell_data.height_br, cfg.level);
		setup[1] = edge_setup(cell_data.height_br, cell_data.height_tr, cfg.level);
		setup[2] = edge_setup(cell_data.height_tl, cell_data.height_tr, cfg.level);
		setup[3] = edge_setup(cell_data.height_bl, cell_data.height_tl, cfg.level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= FRAC_BITS; s++) begin
				vld_q[s] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= cell_valid && produces;
			for (int s = 1; s <= FRAC_BITS; s++) begin
				vld_q[s] <= vld_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_q[0] <= '{cell_data.cell_col, cell_data.cell_row, code, hi};
			for (int e = 0; e < 4; e++) begin
				lane_q[0][e] <= setup[e];
			end
			for (int s = 1; s <= FRAC_BITS; s++) begin
				info_q[s] <= info_q[s-1];
				for (int e = 0; e < 4; e++) begin
					lane_q[s][e] <= div_step(lane_q[s-1][e]);
				end
			end
		end
	end

	always_comb begin
		push_data.cell_col = info_q[FRAC_BITS].cell_col;
		push_data.cell_row = info_q[FRAC_BITS].cell_row;
		push_data.code     = info_q[FRAC_BITS].code;
		push_data.hi       = info_q[FRAC_BITS].hi;
		push_data.t_b      = t_value(lane_q[FRAC_BITS][0]);
		push_data.t_r      = t_value(lane_q[FRAC_BITS][1]);
		push_data.t_t      = t_value(lane_q[FRAC_BITS][2]);
		push_data.t_l      = t_value(lane_q[FRAC_BITS][3]);
	end

endmodule

// File: src/msc_queue.sv
// Small FIFO between the front and back parts.
// Depends on msc_pkg.
module msc_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  msc_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output msc_pkg::qent_t head,
	output logic           empty
);
	import msc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: src/msc_back.sv
// Back part: scales fractions by the pitch and emits one or two segments.
// Depends on msc_pkg.
module msc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  msc_pkg::cfg_t  cfg,
	input  logic           empty,
	input  msc_pkg::qent_t head,
	output logic           pop,
	output logic           seg_valid,
	input  logic           seg_stall,
	output msc_pkg::seg_t  seg
);
	import msc_pkg::*;

	localparam int PW = FRAC_BITS + PITCH_W + 1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pt_t;

	logic               s1_v, idx_q, seg_valid_q;
	logic [3:0]         code_s1;
	logic               hi_s1;
	logic [COORD_W-1:0] cx_s1, ry_s1;
	logic [PITCH_W:0]   fb_s1, fr_s1, ft_s1, fl_s1;
	seg_t               seg_q;

	logic [COORD_W-1:0] cx_n, ry_n;
	logic [PW-1:0]      pb, pr, pt, pl;
	plan_t              plan;
	pt_t                pts [4];
	logic               out_free, emit, last, done;
	edge_t              ea, eb;

	always_comb begin
		cx_n = COORD_W'(head.cell_col) * COORD_W'(cfg.pitch_x);
		ry_n = COORD_W'(head.cell_row) * COORD_W'(cfg.pitch_y);
		pb   = PW'(head.t_b) * PW'(cfg.pitch_x);
		pt   = PW'(head.t_t) * PW'(cfg.pitch_x);
		pr   = PW'(head.t_r) * PW'(cfg.pitch_y);
		pl   = PW'(head.t_l) * PW'(cfg.pitch_y);
	end

	always_comb begin
		plan = msc_plan(code_s1, hi_s1);
		pts[E_BOTTOM] = '{cx_s1 + COORD_W'(fb_s1), ry_s1};
		pts[E_TOP]    = '{cx_s1 + COORD_W'(ft_s1), ry_s1 + COORD_W'(cfg.pitch_y)};
		pts[E_RIGHT]  = '{cx_s1 + COORD_W'(cfg.pitch_x), ry_s1 + COORD_W'(fr_s1)};
		pts[E_LEFT]   = '{cx_s1, ry_s1 + COORD_W'(fl_s1)};
		ea       = idx_q ? plan.a1 : plan.a0;
		eb       = idx_q ? plan.b1 : plan.b0;
		last     = idx_q || !plan.two;
		out_free = !seg_valid_q || !seg_stall;
		emit     = s1_v && out_free;
		done     = emit && last;
		pop      = !empty && (!s1_v || done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v        <= 1'b0;
			idx_q       <= 1'b0;
			seg_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_v <= 1'b1;
			end else if (done) begin
				s1_v <= 1'b0;
			end
			if (emit) begin
				idx_q <= !last;
			end
			if (emit) begin
				seg_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_s1 <= head.code;
			hi_s1   <= head.hi;
			cx_s1   <= cx_n;
			ry_s1   <= ry_n;
			fb_s1   <= pb[PW-1:FRAC_BITS];
			ft_s1   <= pt[PW-1:FRAC_BITS];
			fr_s1   <= pr[PW-1:FRAC_BITS];
			fl_s1   <= pl[PW-1:FRAC_BITS];
		end
		if (emit) begin
			seg_q <= '{pts[ea].x, pts[ea].y, pts[eb].x, pts[eb].y, last};
		end
	end

	assign seg_valid = seg_valid_q;
	assign seg       = seg_q;

endmodule

// File: src/marching_squares_cell_unit.sv
// Channel   Direction  Handshake           Payload
// cell      in         cell_valid/stall    msc_pkg::cell_t
// seg       out        seg_valid/stall     msc_pkg::seg_t
// cfg       in         cfg_valid/ready     cfg_index, cfg_data
//
// One cell per cycle while cell_stall is low.
// Saddle cells emit two segments in turn through the single segment register.
// Front stalls only when its last divider stage waits on a full queue.
// Reset clears control state and loads level 0, pitches 256.
// Top level of the contour cell unit; depends on msc_pkg and the submodules.
`include "assert_macros.svh"
module marching_squares_cell_unit #(
	parameter int GRID_CELLS  = 1023,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cell_valid,
	output logic           cell_stall,
	input  msc_pkg::cell_t cell_data,
	output logic           seg_valid,
	input  logic           seg_stall,
	output msc_pkg::seg_t  seg,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import msc_pkg::*;

	cfg_t  cfg_q;
	qent_t push_data, head;
	logic  q_push, q_full, q_pop, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd0, 16'd256, 16'd256};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL:   cfg_q.level   <= cfg_data;
				CFG_PITCH_X: cfg_q.pitch_x <= cfg_data;
				CFG_PITCH_Y: cfg_q.pitch_y <= cfg_data;
				default: ;
			endcase
		end
	end

	msc_front #(.GRID_CELLS(GRID_CELLS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_data (cell_data),
		.cfg       (cfg_q),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full)
	);

	msc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty)
	);

	msc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (q_empty),
		.head     (head),
		.pop      (q_pop),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg      (seg)
	);

	`MSC_ASSERT_NEVER(a_push_full, q_push && q_full)
	`MSC_ASSERT_NEVER(a_pop_empty, q_pop && q_empty)
	`MSC_ASSERT(a_second_seg, seg_valid && !seg_stall && !seg.last_segment |=> seg_valid)

endmodule

// File: tb/sv/tb.sv
// Testbench of marching_squares_cell_unit: directed cell table, then random cells,
// each segment compared with an in-bench contour predictor. Depends on msc_pkg.
`timescale 1ns / 100ps
module tb;
	import msc_pkg::*;

	localparam int GRID = 1023;
	localparam int LATENCY = FRAC_BITS + 4;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic cell_valid;
	logic cell_stall;
	cell_t cell_data;
	logic seg_valid;
	logic seg_stall;
	seg_t seg;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	marching_squares_cell_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		cell_t c;
		logic has_exp;
		seg_t exp_seg;
	} row_t;

	logic [15:0] level_q, pitch_x_q, pitch_y_q;
	seg_t expected_segs[$];
	int errors = 0;
	int dir_errors;
	int idle_cycles = 0;
	bit rx_hold;
	bit quiet;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [FRAC_BITS:0] edge_frac(logic [15:0] va, logic [15:0] vb);
		longint diff, num, an, ad;
		diff = longint'(vb) - longint'(va);
		num = longint'(level_q) - longint'(va);
		if (diff == 0)
			return (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
		if (num == 0 || ((num > 0) != (diff > 0)))
			return '0;
		an = num < 0 ? -num : num;
		ad = diff < 0 ? -diff : diff;
		if (an >= ad)
			return (FRAC_BITS+1)'(1) << FRAC_BITS;
		return (FRAC_BITS+1)'((an << FRAC_BITS) / ad);
	endfunction

	function automatic logic [COORD_W-1:0] place(longint idx, longint pitch, longint t);
		return COORD_W'(idx * pitch + ((t * pitch) >> FRAC_BITS));
	endfunction

	function automatic seg_t make_seg(logic [COORD_W-1:0] p[4][2], edge_t a, edge_t b,
			logic last);
		seg_t s;
		s.start_x = p[a][0];
		s.start_y = p[a][1];
		s.end_x = p[b][0];
		s.end_y = p[b][1];
		s.last_segment = last;
		return s;
	endfunction

	task automatic add_expected(seg_t s);
		expected_segs.insert(expected_segs.size(), s);
	endtask

	task automatic predict_contour(cell_t c);
		logic [COORD_W-1:0] p[4][2];
		logic [3:0] code;
		logic hi;
		longint col, row;
		col = longint'(c.cell_col);
		row = longint'(c.cell_row);
		if (col >= GRID || row >= GRID)
			return;
		code = {c.height_tl >= level_q, c.height_tr >= level_q,
			c.height_br >= level_q, c.height_bl >= level_q};
		if (code == 4'd0 || code == 4'd15)
			return;
		p[E_BOTTOM][0] = place(col, pitch_x_q, edge_frac(c.height_bl, c.height_br));
		p[E_BOTTOM][1] = COORD_W'(row * pitch_y_q);
		p[E_TOP][0] = place(col, pitch_x_q, edge_frac(c.height_tl, c.height_tr));
		p[E_TOP][1] = COORD_W'((row + 1) * pitch_y_q);
		p[E_RIGHT][0] = COORD_W'((col + 1) * pitch_x_q);
		p[E_RIGHT][1] = place(row, pitch_y_q, edge_frac(c.height_br, c.height_tr));
		p[E_LEFT][0] = COORD_W'(col * pitch_x_q);
		p[E_LEFT][1] = place(row, pitch_y_q, edge_frac(c.height_bl, c.height_tl));
		hi = (longint'(c.height_bl) + c.height_br + c.height_tr + c.height_tl)
			>= (longint'(level_q) << 2);
		case (code)
			4'd1, 4'd14: add_expected(make_seg(p, E_LEFT, E_BOTTOM, 1'b1));
			4'd2, 4'd13: add_expected(make_seg(p, E_BOTTOM, E_RIGHT, 1'b1));
			4'd3, 4'd12: add_expected(make_seg(p, E_LEFT, E_RIGHT, 1'b1));
			4'd4, 4'd11: add_expected(make_seg(p, E_RIGHT, E_TOP, 1'b1));
			4'd6, 4'd9: add_expected(make_seg(p, E_BOTTOM, E_TOP, 1'b1));
			4'd7, 4'd8: add_expected(make_seg(p, E_LEFT, E_TOP, 1'b1));
			default: begin
				if ((code == 4'd5) == hi) begin
					add_expected(make_seg(p, E_LEFT, E_TOP, 1'b0));
					add_expected(make_seg(p, E_BOTTOM, E_RIGHT, 1'b1));
				end else begin
					add_expected(make_seg(p, E_LEFT, E_BOTTOM, 1'b0));
					add_expected(make_seg(p, E_TOP, E_RIGHT, 1'b1));
				end
			end
		endcase
	endtask

	// output checker
	always @(posedge clk) begin
		seg_t e;
		if (arst_n && seg_valid && !seg_stall) begin
			if (expected_segs.size() == 0) begin
				$error("unexpected segment %p", seg);
				errors++;
			end else begin
				e = expected_segs.pop_front();
				if (seg.start_x !== e.start_x) begin
					$error("start_x exp %0d got %0d", e.start_x, seg.start_x);
					errors++;
				end
				if (seg.start_y !== e.start_y) begin
					$error("start_y exp %0d got %0d", e.start_y, seg.start_y);
					errors++;
				end
				if (seg.end_x !== e.end_x) begin
					$error("end_x exp %0d got %0d", e.end_x, seg.end_x);
					errors++;
				end
				if (seg.end_y !== e.end_y) begin
					$error("end_y exp %0d got %0d", e.end_y, seg.end_y);
					errors++;
				end
				if (seg.last_segment !== e.last_segment) begin
					$error("last_segment exp %0d got %0d", e.last_segment,
						seg.last_segment);
					errors++;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			seg_stall <= 1'b0;
		else
			seg_stall <= rx_hold || (!quiet && $urandom_range(99) < 8);
	end

	// watchdog
	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (seg_valid && !seg_stall)
				|| (cfg_valid && cfg_ready) || rx_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("** marching_squares_cell_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_cell(cell_t c);
		cfg_valid <= 1'b0;
		while (!quiet && $urandom_range(99) < 8) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_data <= c;
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
		predict_contour(c);
	endtask

	task automatic drain;
		cell_valid <= 1'b0;
		while (expected_segs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_LEVEL: level_q = val;
			CFG_PITCH_X: pitch_x_q = val;
			default: pitch_y_q = val;
		endcase
	endtask

	function automatic cell_t rand_cell(bit wide);
		cell_t c;
		logic [15:0] base;
		c.cell_col = $urandom_range(99) < 3 ? 10'(1023) : 10'($urandom_range(1022));
		c.cell_row = $urandom_range(99) < 3 ? 10'(1023) : 10'($urandom_range(1022));
		if (wide) begin
			c.height_bl = 16'($urandom);
			c.height_br = 16'($urandom);
			c.height_tr = 16'($urandom);
			c.height_tl = 16'($urandom);
		end else begin
			base = level_q;
			c.height_bl = base + 16'($urandom_range(64)) - 16'd32;
			c.height_br = base + 16'($urandom_range(64)) - 16'd32;
			c.height_tr = base + 16'($urandom_range(64)) - 16'd32;
			c.height_tl = base + 16'($urandom_range(64)) - 16'd32;
		end
		return c;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_cell(rand_cell($urandom_range(3) == 0));
	endtask

	row_t dir_rows[$];

	initial begin
		row_t r;
		seg_t s;
		dir_errors = 0;
		rx_hold = 1'b0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cell_valid = 1'b0;
		cell_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LEVEL;
		cfg_data = '0;
		level_q = 16'd0;
		pitch_x_q = 16'd256;
		pitch_y_q = 16'd256;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all corners below the level, code 0, no segment
		r.c = '{10'd0, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		r.has_exp = 1'b0;
		dir_rows.insert(dir_rows.size(), r);
		write_reg(CFG_LEVEL, 16'd100);
		// bl high only, level midway on left and bottom edges: half pitch
		r.c = '{10'd0, 10'd0, 16'd200, 16'd0, 16'd0, 16'd0};
		s = '{26'd0, 26'd128, 26'd128, 26'd0, 1'b1};
		r.has_exp = 1'b1;
		r.exp_seg = s;
		dir_rows.insert(dir_rows.size(), r);
		r.has_exp = 1'b0;
		for (int code = 0; code < 16; code++) begin
			r.c = '{10'(code * 7), 10'(code * 3),
				code[0] ? 16'hFFFF : 16'd0, code[1] ? 16'd150 : 16'd10,
				code[2] ? 16'd100 : 16'd99, code[3] ? 16'd400 : 16'd0};
			dir_rows.insert(dir_rows.size(), r);
		end
		// saddles, both corner-sum sides
		r.c = '{10'd5, 10'd5, 16'd101, 16'd0, 16'd101, 16'd0};
		dir_rows.insert(dir_rows.size(), r);
		r.c = '{10'd5, 10'd5, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
		dir_rows.insert(dir_rows.size(), r);
		r.c = '{10'd5, 10'd5, 16'd0, 16'd101, 16'd0, 16'd101};
		dir_rows.insert(dir_rows.size(), r);
		r.c = '{10'd5, 10'd5, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		dir_rows.insert(dir_rows.size(), r);
		// outside grid and max index
		r.c = '{10'd1023, 10'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
		dir_rows.insert(dir_rows.size(), r);
		r.c = '{10'd0, 10'd1023, 16'hFFFF, 16'd0, 16'd0, 16'd0};
		dir_rows.insert(dir_rows.size(), r);
		r.c = '{10'd1022, 10'd1022, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
		dir_rows.insert(dir_rows.size(), r);

		foreach (dir_rows[i]) begin
			send_cell(dir_rows[i].c);
			if (dir_rows[i].has_exp && (expected_segs.size() == 0
					|| expected_segs[$] !== dir_rows[i].exp_seg)) begin
				$error("directed row %0d: predictor disagrees with table", i);
				dir_errors++;
			end
		end
		drain();

		// extreme settings
		write_reg(CFG_LEVEL, 16'hFFFF);
		write_reg(CFG_PITCH_X, 16'hFFFF);
		write_reg(CFG_PITCH_Y, 16'd1);
		random_phase(150);
		drain();
		write_reg(CFG_LEVEL, 16'd0);
		write_reg(CFG_PITCH_X, 16'd1);
		write_reg(CFG_PITCH_Y, 16'hFFFF);
		random_phase(100);
		drain();

		write_reg(CFG_LEVEL, 16'h8000);
		write_reg(CFG_PITCH_X, 16'd300);
		write_reg(CFG_PITCH_Y, 16'd77);
		// receiver holds off while cells keep coming
		fork
			begin
				rx_hold = 1'b1;
				repeat (200) @(posedge clk);
				rx_hold = 1'b0;
			end
			random_phase(150);
		join
		// sender pauses until all segments are out
		cell_valid <= 1'b0;
		while (expected_segs.size() != 0)
			@(posedge clk);
		quiet = 1'b1;
		random_phase(200);
		quiet = 1'b0;
		drain();

		write_reg(CFG_LEVEL, 16'($urandom));
		write_reg(CFG_PITCH_X, 16'($urandom_range(65535, 1)));
		write_reg(CFG_PITCH_Y, 16'($urandom_range(65535, 1)));
		random_phase(400);
		drain();

		if (errors + dir_errors == 0)
			$display("** marching_squares_cell_unit: PASSED **");
		else
			$display("** marching_squares_cell_unit: FAILED **");
		$finish;
	end
endmodule
